### hdl/base64_stream_codec_unit_assert.svh
// ----------------------------------------------------------------------------
// base64 codec assertion macros
// clocked property wrappers shared by the checker
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_UNIT_ASSERT_SVH
`define BASE64_STREAM_CODEC_UNIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define B64_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("b64 assertion failed");

// implication form
`define B64_ASSERT_IMP(lbl, ante, cons) \
    `B64_ASSERT(lbl, (ante) |-> (cons))

`endif

### hdl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// shared types, codes and alphabet functions of the base64 codec
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam logic       C_DIR_ENC = 1'b0;
    localparam logic       C_DIR_DEC = 1'b1;
    localparam logic [7:0] C_PAD     = 8'h3D;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            last;
        logic            err;
    } t_grp;

    function automatic logic [7:0] f_enc_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'(8'h41 + {2'b00, s});
        end else if (s < 6'd52) begin
            c = 8'(8'h61 + {2'b00, s} - 8'd26);
        end else if (s < 6'd62) begin
            c = 8'(8'h30 + {2'b00, s} - 8'd52);
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // {valid, sextet}
    function automatic logic [6:0] f_sextet(input logic [7:0] c);
        logic [6:0] r;
        if (c inside {[8'h41:8'h5A]}) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c inside {[8'h61:8'h7A]}) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end else begin
            r = 7'd0;
        end
        return r;
    endfunction

endpackage

### hdl/b64_if.sv
// ----------------------------------------------------------------------------
// b64 channel interfaces
// input item, result item and direction write channels
// ----------------------------------------------------------------------------
interface b64_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;
    modport source (output valid, output out_byte, output out_last, output out_error,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input out_error,
                    output ready);
endinterface

interface b64_cfg_if;
    logic valid;
    logic ready;
    logic direction;
    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

### hdl/b64_core.sv
// ----------------------------------------------------------------------------
// b64_core
// message state and group logic: turns one item into a group of zero to four results
// ----------------------------------------------------------------------------
module b64_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_dir,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output b64_pkg::t_grp o_grp
);
    import b64_pkg::*;

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;
    localparam logic [1:0] PH_3 = 2'd3;

    logic        r_dir;
    logic [17:0] r_acc, n_acc;
    logic [1:0]  r_ph, n_ph;
    logic        r_inv, n_inv;
    logic        r_pad, n_pad;

    logic [6:0]  sx;
    logic        is_pad;
    logic [5:0]  s;
    logic [1:0]  ph_e;
    logic [23:0] triple;
    logic [1:0]  drop;
    t_grp        grp;

    always_comb begin
        n_acc  = r_acc;
        n_ph   = r_ph;
        n_inv  = r_inv;
        n_pad  = r_pad;
        grp    = '0;
        sx     = f_sextet(i_byte);
        is_pad = (i_byte == C_PAD);
        s      = (is_pad || !sx[6]) ? 6'd0 : sx[5:0];
        ph_e   = (r_ph == PH_3) ? PH_0 : r_ph;
        triple = {r_acc, s};
        drop   = 2'd0;
        if (r_dir == C_DIR_ENC) begin
            case (ph_e)
                PH_0: begin
                    grp.bytes[0] = f_enc_char(i_byte[7:2]);
                    grp.bytes[1] = f_enc_char({i_byte[1:0], 4'd0});
                    grp.bytes[2] = C_PAD;
                    grp.bytes[3] = C_PAD;
                    grp.cnt      = i_last ? 3'd4 : 3'd1;
                    n_acc        = {16'd0, i_byte[1:0]};
                    n_ph         = PH_1;
                end
                PH_1: begin
                    grp.bytes[0] = f_enc_char({r_acc[1:0], i_byte[7:4]});
                    grp.bytes[1] = f_enc_char({i_byte[3:0], 2'd0});
                    grp.bytes[2] = C_PAD;
                    grp.cnt      = i_last ? 3'd3 : 3'd1;
                    n_acc        = {14'd0, i_byte[3:0]};
                    n_ph         = PH_2;
                end
                default: begin
                    grp.bytes[0] = f_enc_char({r_acc[3:0], i_byte[7:6]});
                    grp.bytes[1] = f_enc_char(i_byte[5:0]);
                    grp.cnt      = 3'd2;
                    n_acc        = '0;
                    n_ph         = PH_0;
                end
            endcase
            grp.last = i_last;
        end else begin
            n_inv = r_inv | (!is_pad && !sx[6]);
            case (r_ph)
                PH_0: n_acc = {s, 12'd0};
                PH_1: n_acc = r_acc | {6'd0, s, 6'd0};
                PH_2: begin
                    n_acc = r_acc | {12'd0, s};
                    n_pad = is_pad;
                end
                default: n_acc = '0;
            endcase
            if (r_ph != PH_3) begin
                n_ph = r_ph + 2'd1;
                if (i_last) begin
                    grp.cnt  = 3'd1;
                    grp.last = 1'b1;
                    grp.err  = 1'b1;
                end
            end else begin
                if (i_last) begin
                    drop = {1'b0, r_pad} + {1'b0, is_pad};
                end
                grp.bytes[0] = triple[23:16];
                grp.bytes[1] = triple[15:8];
                grp.bytes[2] = triple[7:0];
                grp.cnt      = 3'd3 - {1'b0, drop};
                grp.last     = i_last;
                grp.err      = i_last & n_inv;
                n_ph         = PH_0;
                n_pad        = 1'b0;
            end
        end
        if (i_last) begin
            n_acc = '0;
            n_ph  = PH_0;
            n_inv = 1'b0;
            n_pad = 1'b0;
        end
    end

    assign o_grp = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= C_DIR_ENC;
            r_acc <= '0;
            r_ph  <= PH_0;
            r_inv <= 1'b0;
            r_pad <= 1'b0;
        end else if (i_cfg_we) begin
            r_dir <= i_cfg_dir;
            r_acc <= '0;
            r_ph  <= PH_0;
            r_inv <= 1'b0;
            r_pad <= 1'b0;
        end else if (i_take) begin
            r_acc <= n_acc;
            r_ph  <= n_ph;
            r_inv <= n_inv;
            r_pad <= n_pad;
        end
    end

endmodule

### hdl/b64_emit.sv
// ----------------------------------------------------------------------------
// b64_emit
// result register: holds one group and, while the output is ready, hands it out one item per cycle
// ----------------------------------------------------------------------------
module b64_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  b64_pkg::t_grp i_grp,
    input  logic          i_ready,
    output logic          o_free,
    output logic          o_valid,
    output logic [7:0]    o_byte,
    output logic          o_last,
    output logic          o_err
);
    import b64_pkg::*;

    logic            r_valid;
    logic [3:0][7:0] r_bytes;
    logic [1:0]      r_idx;
    logic [1:0]      r_lidx;
    logic            r_last;
    logic            r_err;
    logic            at_end;
    logic            pop;
    logic [2:0]      lidx_w;

    assign at_end  = (r_idx == r_lidx);
    assign pop     = r_valid && i_ready;
    assign o_free  = !r_valid || (pop && at_end);
    assign o_valid = r_valid;
    assign o_byte  = r_bytes[r_idx];
    assign o_last  = r_last && at_end;
    assign o_err   = r_err && at_end;
    assign lidx_w  = i_grp.cnt - 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (pop) begin
            if (at_end) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_grp.bytes;
            r_lidx  <= lidx_w[1:0];
            r_last  <= i_grp.last;
            r_err   <= i_grp.err;
        end
    end

endmodule

### hdl/base64_stream_codec_unit.sv
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// streaming base64 encoder/decoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// Items enter an input register; one item per cycle moves from there through
// the group logic into a result register unless it is busy, and results
// go out one per cycle while the output is ready. Input is taken while
// earlier results drain. The output port sets the rate: encoding gives four
// results per three items, a final encode item gives up to four results, and
// decoding gives three results per four items, so decoding input runs at one
// item per cycle when unstalled. Writing the direction clears message state.
module base64_stream_codec_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64_cfg_if.sink    i_cfg,
    b64_item_if.sink   i_in,
    b64_res_if.source  o_out
);
    import b64_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       take;
    logic       emit_free;
    logic       has_res;
    t_grp       grp;

    assign has_res     = (grp.cnt != 3'd0);
    assign take        = r_in_valid && (!has_res || emit_free);
    assign i_in.ready  = !r_in_valid || take;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    b64_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg.valid),
        .i_cfg_dir (i_cfg.direction),
        .i_take    (take),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_grp     (grp)
    );

    b64_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && has_res),
        .i_grp   (grp),
        .i_ready (o_out.ready),
        .o_free  (emit_free),
        .o_valid (o_out.valid),
        .o_byte  (o_out.out_byte),
        .o_last  (o_out.out_last),
        .o_err   (o_out.out_error)
    );

endmodule

### hdl/b64_checker.sv
// ----------------------------------------------------------------------------
// b64_checker
// port level checks of the base64 codec, bound to the top level
// ----------------------------------------------------------------------------
`include "base64_stream_codec_unit_assert.svh"

module b64_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_valid,
    input logic       i_cfg_ready,
    input logic       i_cfg_dir,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_out_error
);
    import b64_pkg::*;

    logic r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= C_DIR_ENC;
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_dir <= i_cfg_dir;
        end
    end

    `B64_ASSERT_IMP(a_out_hold, i_out_valid && !i_out_ready, ##1 i_out_valid)
    `B64_ASSERT_IMP(a_err_on_last, i_out_valid && i_out_error, i_out_last)
    `B64_ASSERT_IMP(a_no_err_enc, i_out_valid && r_dir == C_DIR_ENC, !i_out_error)
    `B64_ASSERT_IMP(a_len_err_zero, i_out_valid && i_out_error && r_dir == C_DIR_DEC
        && i_out_byte != 8'd0, i_out_last)

endmodule

bind base64_stream_codec_unit b64_checker u_b64_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_dir   (i_cfg.direction),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last),
    .i_out_error (o_out.out_error)
);

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_stream_codec_unit. A scoreboard predicts
// every result of each accepted item in both directions. It covers padding,
// invalid characters, bad decode lengths and pads away from the final group.
// Directed messages come first, then random messages with random content.
// They run under four sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64_pkg::*;

    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int    CYCLE_LIMIT  = 200000;
    localparam int    DRAIN_CYCLES = 8;
    localparam int    ITEMS_PER_PHASE = 18;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } b64_result_t;

    typedef logic [7:0] byte_q_t[$];

    class b64_scoreboard;
        b64_result_t pending_results[$];
        int          sextet_lut[256];
        logic        dir;
        logic [17:0] acc;
        logic [1:0]  phase;
        logic        bad_char;
        logic        pad_third;
        int          errors;

        function new();
            for (int i = 0; i < 256; i++) begin
                sextet_lut[i] = 64;
            end
            for (int i = 0; i < 64; i++) begin
                sextet_lut[B64_ALPHABET[i]] = i;
            end
            errors = 0;
            set_direction(C_DIR_ENC);
        endfunction

        function void clear_message();
            acc       = '0;
            phase     = '0;
            bad_char  = 1'b0;
            pad_third = 1'b0;
        endfunction

        function void set_direction(logic d);
            dir = d;
            clear_message();
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic [7:0] char_of(logic [5:0] s);
            return B64_ALPHABET[s];
        endfunction

        function void predict_encode(logic [7:0] b, logic last);
            logic [7:0] ch[4];
            int         n;
            n = 0;
            if (phase == 2'd2) begin
                ch[n++] = char_of({acc[3:0], b[7:6]});
                ch[n++] = char_of(b[5:0]);
                acc     = '0;
                phase   = 2'd0;
            end else if (phase == 2'd1) begin
                ch[n++] = char_of({acc[1:0], b[7:4]});
                acc     = {14'd0, b[3:0]};
                phase   = 2'd2;
                if (last) begin
                    ch[n++] = char_of({b[3:0], 2'b00});
                    ch[n++] = C_PAD;
                end
            end else begin
                ch[n++] = char_of(b[7:2]);
                acc     = {16'd0, b[1:0]};
                phase   = 2'd1;
                if (last) begin
                    ch[n++] = char_of({b[1:0], 4'b0000});
                    ch[n++] = C_PAD;
                    ch[n++] = C_PAD;
                end
            end
            for (int i = 0; i < n; i++) begin
                pending_results.push_back('{ch[i], last && (i == n - 1), 1'b0});
            end
            if (last) begin
                clear_message();
            end
        endfunction

        function void predict_decode(logic [7:0] b, logic last);
            logic        is_pad;
            logic [5:0]  s;
            logic [23:0] triple;
            int          n;
            is_pad = (b == C_PAD);
            s      = '0;
            if (!is_pad) begin
                if (sextet_lut[b] > 63) begin
                    bad_char = 1'b1;
                end else begin
                    s = 6'(sextet_lut[b]);
                end
            end
            if (phase != 2'd3) begin
                case (phase)
                    2'd0: acc = {s, 12'd0};
                    2'd1: acc[11:6] = s;
                    default: begin
                        acc[5:0]  = s;
                        pad_third = is_pad;
                    end
                endcase
                phase = phase + 2'd1;
                if (last) begin
                    pending_results.push_back('{8'h00, 1'b1, 1'b1});
                    clear_message();
                end
            end else begin
                triple = {acc, s};
                n      = 3;
                if (last) begin
                    n = n - int'(pad_third) - int'(is_pad);
                end
                for (int i = 0; i < n; i++) begin
                    pending_results.push_back('{triple[23 - 8 * i -: 8],
                                                last && (i == n - 1),
                                                last && (i == n - 1) && bad_char});
                end
                acc       = '0;
                phase     = '0;
                pad_third = 1'b0;
                if (last) begin
                    clear_message();
                end
            end
        endfunction

        function void note_item(logic [7:0] b, logic last);
            if (dir == C_DIR_ENC) begin
                predict_encode(b, last);
            end else begin
                predict_decode(b, last);
            end
        endfunction

        function void check_result(logic [7:0] b, logic last, logic err);
            b64_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual byte %02h last %0b err %0b",
                         $time, b, last, err);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (e.data !== b || e.last !== last || e.err !== err) begin
                $display("%0t: mismatch, expected byte %02h last %0b err %0b, %s %02h %0b %0b",
                         $time, e.data, e.last, e.err, "actual", b, last, err);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   send_idle;
    int   recv_stall;
    logic cur_dir;

    b64_scoreboard sb = new();

    b64_cfg_if  cfg_ch();
    b64_item_if in_ch();
    b64_res_if  out_ch();

    base64_stream_codec_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.set_direction(cfg_ch.direction);
            end
            if (in_ch.valid && in_ch.ready) begin
                sb.note_item(in_ch.in_byte, in_ch.in_last);
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.out_byte, out_ch.out_last, out_ch.out_error);
            end
        end
    end

    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_msg(input byte_q_t msg);
        foreach (msg[i]) begin
            send_item(msg[i], i == msg.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        byte_q_t msg;
        for (int i = 0; i < s.len(); i++) begin
            msg.push_back(s[i]);
        end
        send_msg(msg);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_direction(input logic d);
        wait_drained();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.direction <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_dir = d;
    endtask

    function automatic byte_q_t random_message(logic d);
        byte_q_t msg;
        int      groups;
        int      pads;
        int      cut;
        if (d == C_DIR_ENC) begin
            repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(255)));
        end else if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(255)));
        end else begin
            groups = $urandom_range(1, 2);
            repeat (4 * groups) msg.push_back(B64_ALPHABET[$urandom_range(63)]);
            pads = $urandom_range(2);
            if (pads >= 1) msg[msg.size() - 1] = C_PAD;
            if (pads == 2) msg[msg.size() - 2] = C_PAD;
            if ($urandom_range(99) < 10) begin
                msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
            end
            if ($urandom_range(99) < 8) begin
                msg[$urandom_range(msg.size() - 1)] = C_PAD;
            end
            if ($urandom_range(99) < 10) begin
                cut = $urandom_range(1, 3);
                repeat (cut) void'(msg.pop_back());
            end
        end
        return msg;
    endfunction

    initial begin
        byte_q_t msg;
        int      sent;
        rst_n            <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.direction <= C_DIR_ENC;
        in_ch.valid      <= 1'b0;
        in_ch.in_byte    <= '0;
        in_ch.in_last    <= 1'b0;
        send_idle        = 0;
        recv_stall       = 0;
        cur_dir          = C_DIR_ENC;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: encode partial and full groups
        write_direction(C_DIR_ENC);
        send_msg({8'h00});
        send_msg({8'hFF, 8'hFF});
        send_msg({8'h00, 8'hFF, 8'h80});

        // directed: decode pads, odd pads, bad length, invalid characters
        write_direction(C_DIR_DEC);
        send_text("+/9=");
        send_text("QQ==");
        send_text("AB=C");
        send_text("=Az9Q");
        send_msg({8'h61, 8'h2A, 8'h42, 8'hFF});

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 57; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 57; end
                default: begin send_idle = 18; recv_stall = 18; end
            endcase
            write_direction(p[0]);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(3) == 0) begin
                    write_direction(1'($urandom_range(1)));
                end
                msg = random_message(cur_dir);
                send_msg(msg);
                sent += msg.size();
            end
            // hold off the sender until every result is back
            wait_drained();
        end

        wait_drained();
        repeat (32) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
